FILE: sv/tmps_pkg.sv
package tmps_pkg;

  localparam int TILE_SLOTS = 9;
  localparam int TILE_SIZE = 128;
  localparam int SCREEN_SIZE = 360;
  localparam int TEXELS_PER_TILE = TILE_SIZE * TILE_SIZE;
  localparam int TEXEL_DEPTH = TILE_SLOTS * TEXELS_PER_TILE;
  localparam int TEXEL_AW = $clog2(TEXEL_DEPTH);
  localparam int PIX_W = $clog2(TILE_SIZE);
  localparam int AXIS_STAGES = 6;

  localparam logic [9:0] SCREEN_HALF = 10'(SCREEN_SIZE / 2);
  localparam logic [15:0] FILL_COLOR = 16'h1082;
  // common multiple of all spans, large enough to make every world position positive
  localparam logic [27:0] WORLD_BIAS = 28'd67112500;

  localparam logic [1:0] OP_TAG = 2'd0;
  localparam logic [1:0] OP_TEXEL = 2'd1;
  localparam logic [1:0] OP_RENDER = 2'd2;

  localparam logic [1:0] CFG_VIEW_X = 2'd0;
  localparam logic [1:0] CFG_VIEW_Z = 2'd1;
  localparam logic [1:0] CFG_ZOOM = 2'd2;
  localparam logic [1:0] CFG_WORLD = 2'd3;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] slot;
    logic tag_valid;
    logic [1:0] tag_world;
    logic [1:0] tag_detail;
    logic signed [16:0] tag_tile_x;
    logic signed [16:0] tag_tile_z;
    logic [13:0] texel_index;
    logic [15:0] texel_value;
    logic [8:0] screen_x;
    logic [8:0] screen_y;
  } item_t;

  function automatic logic [5:0] bpp_of(input logic [2:0] zoom);
    logic [5:0] b;
    case (zoom)
      3'd0: b = 6'd1;
      3'd1: b = 6'd2;
      3'd2: b = 6'd5;
      3'd3: b = 6'd10;
      3'd4: b = 6'd25;
      default: b = 6'd50;
    endcase
    return b;
  endfunction

  function automatic logic [1:0] detail_of(input logic [2:0] zoom);
    logic [1:0] d;
    case (zoom)
      3'd0, 3'd1: d = 2'd1;
      3'd2, 3'd3: d = 2'd2;
      default: d = 2'd3;
    endcase
    return d;
  endfunction

  function automatic logic [13:0] span_of(input logic [1:0] detail);
    logic [13:0] s;
    case (detail)
      2'd1: s = 14'd500;
      2'd2: s = 14'd2500;
      default: s = 14'd12500;
    endcase
    return s;
  endfunction

  // ceil(2^37 / (span/4)), exact for quotients of 25-bit values
  function automatic logic [30:0] recip_of(input logic [1:0] detail);
    logic [30:0] r;
    case (detail)
      2'd1: r = 31'd1099511628;
      2'd2: r = 31'd219902326;
      default: r = 31'd43980466;
    endcase
    return r;
  endfunction

  // ceil(2^35 / span), exact for 21-bit dividends
  function automatic logic [26:0] frac_recip_of(input logic [1:0] detail);
    logic [26:0] r;
    case (detail)
      2'd1: r = 27'd68719477;
      2'd2: r = 27'd13743896;
      default: r = 27'd2748780;
    endcase
    return r;
  endfunction

  // world bias expressed in tiles
  function automatic logic [17:0] bias_tiles_of(input logic [1:0] detail);
    logic [17:0] m;
    case (detail)
      2'd1: m = 18'd134225;
      2'd2: m = 18'd26845;
      default: m = 18'd5369;
    endcase
    return m;
  endfunction

endpackage

FILE: sv/tiled_map_pixel_sampler.sv
// channel   dir  handshake          payload
// s         in   s_tvalid/s_tready  s_tuser opcode, s_tdata tag/texel/screen fields
// m         out  m_tvalid/m_tready  m_tuser tile_hit, m_tdata color/out_x/out_y
// cfg       in   cfg_we             cfg_index, cfg_data
// one transaction accepted per clock while s_tready is high; each render yields one result on m
// a render passes through the coordinate pipeline: offset multiply, bias add,
// reciprocal multiply, remainder, texel multiply, texel bit select, then tag match and texel read
// rst clears tag valid bits and pipeline valid bits at once; texels stay unknown
// a stall on m freezes only the stages that are full, bubbles are squeezed out
module tiled_map_pixel_sampler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // slot[3:0] tag_valid[4] tag_world[6:5] tag_detail[8:7] tag_tile_x[25:9]
  // tag_tile_z[42:26] texel_index[56:43] texel_value[72:57] screen_x[81:73]
  // screen_y[90:82], zero above
  input  logic [95:0] s_tdata,
  // opcode[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // color[15:0] out_x[24:16] out_y[33:25], zero above
  output logic [39:0] m_tdata,
  // tile_hit[0]
  output logic        m_tuser,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [25:0] cfg_data
);

  logic signed [25:0] view_x;
  logic signed [25:0] view_z;
  logic [2:0] zoom_level;
  logic [1:0] world_select;

  tmps_pkg::item_t in_item;
  tmps_pkg::item_t stage_item [tmps_pkg::AXIS_STAGES];
  logic [tmps_pkg::AXIS_STAGES-1:0] stage_valid;
  logic [tmps_pkg::AXIS_STAGES:0] en;

  logic [5:0] bpp;
  logic [1:0] detail;
  logic signed [18:0] tile_x;
  logic signed [18:0] tile_z;
  logic [tmps_pkg::PIX_W-1:0] pix_x;
  logic [tmps_pkg::PIX_W-1:0] pix_z;
  logic out_hit;
  logic [15:0] out_color;
  logic [8:0] out_x;
  logic [8:0] out_y;

  assign in_item = '{
    opcode:      s_tuser,
    slot:        s_tdata[3:0],
    tag_valid:   s_tdata[4],
    tag_world:   s_tdata[6:5],
    tag_detail:  s_tdata[8:7],
    tag_tile_x:  s_tdata[25:9],
    tag_tile_z:  s_tdata[42:26],
    texel_index: s_tdata[56:43],
    texel_value: s_tdata[72:57],
    screen_x:    s_tdata[81:73],
    screen_y:    s_tdata[90:82]
  };

  assign bpp = tmps_pkg::bpp_of(zoom_level);
  assign detail = tmps_pkg::detail_of(zoom_level);

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    en[tmps_pkg::AXIS_STAGES] = !m_tvalid || m_tready;
    for (int k = tmps_pkg::AXIS_STAGES - 1; k >= 0; k--) begin
      en[k] = !stage_valid[k] || en[k+1];
    end
  end

  assign s_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      view_x <= '0;
      view_z <= '0;
      zoom_level <= '0;
      world_select <= '0;
      stage_valid <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tmps_pkg::CFG_VIEW_X: view_x <= cfg_data;
          tmps_pkg::CFG_VIEW_Z: view_z <= cfg_data;
          tmps_pkg::CFG_ZOOM: zoom_level <= cfg_data[2:0];
          tmps_pkg::CFG_WORLD: world_select <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (en[0]) begin
        stage_valid[0] <= s_tvalid;
      end
      for (int k = 1; k < tmps_pkg::AXIS_STAGES; k++) begin
        if (en[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      stage_item[0] <= in_item;
    end
    for (int k = 1; k < tmps_pkg::AXIS_STAGES; k++) begin
      if (en[k]) begin
        stage_item[k] <= stage_item[k-1];
      end
    end
  end

  tmps_axis u_axis_x (
    .clk    (clk),
    .en     (en[tmps_pkg::AXIS_STAGES-1:0]),
    .scr    (in_item.screen_x),
    .view   (view_x),
    .bpp    (bpp),
    .detail (detail),
    .tile   (tile_x),
    .texel  (pix_x)
  );

  tmps_axis u_axis_z (
    .clk    (clk),
    .en     (en[tmps_pkg::AXIS_STAGES-1:0]),
    .scr    (in_item.screen_y),
    .view   (view_z),
    .bpp    (bpp),
    .detail (detail),
    .tile   (tile_z),
    .texel  (pix_z)
  );

  tmps_lookup u_lookup (
    .clk       (clk),
    .rst       (rst),
    .en        (en[tmps_pkg::AXIS_STAGES]),
    .st_valid  (stage_valid[tmps_pkg::AXIS_STAGES-1]),
    .st_item   (stage_item[tmps_pkg::AXIS_STAGES-1]),
    .tile_x    (tile_x),
    .tile_z    (tile_z),
    .pix_x     (pix_x),
    .pix_z     (pix_z),
    .world     (world_select),
    .detail    (detail),
    .out_valid (m_tvalid),
    .out_hit   (out_hit),
    .out_color (out_color),
    .out_x     (out_x),
    .out_y     (out_y)
  );

  assign m_tdata = {6'b0, out_y, out_x, out_color};
  assign m_tuser = out_hit;

endmodule

FILE: sv/tmps_axis.sv
module tmps_axis (
  input  logic                     clk,
  input  logic [5:0]               en,
  input  logic [8:0]               scr,
  input  logic signed [25:0]       view,
  input  logic [5:0]               bpp,
  input  logic [1:0]               detail,
  output logic signed [18:0]       tile,
  output logic [tmps_pkg::PIX_W-1:0] texel
);

  logic signed [16:0] ofs;
  logic [26:0] u2;
  logic [26:0] u3;
  logic [55:0] prod3;
  logic [13:0] rem4;
  logic signed [18:0] tile4;
  logic signed [18:0] tile5;
  logic [47:0] prod5;

  logic signed [9:0] centred;
  logic signed [27:0] u_sum;
  logic [18:0] quot;
  logic [31:0] quot_span;
  logic [26:0] rem_full;
  logic signed [19:0] tile_full;

  assign centred = $signed({1'b0, scr}) - $signed(tmps_pkg::SCREEN_HALF);
  assign u_sum = 28'(view) + 28'(ofs) + $signed(tmps_pkg::WORLD_BIAS);
  assign quot = prod3[55:37];
  assign quot_span = 32'(quot) * 32'(tmps_pkg::span_of(detail));
  assign rem_full = u3 - quot_span[26:0];
  assign tile_full = $signed({1'b0, quot}) - $signed({2'b0, tmps_pkg::bias_tiles_of(detail)});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ofs <= 17'(centred * $signed({1'b0, bpp}));
    end
    if (en[1]) begin
      u2 <= u_sum[26:0];
    end
    if (en[2]) begin
      prod3 <= 56'(u2[26:2]) * 56'(tmps_pkg::recip_of(detail));
      u3 <= u2;
    end
    if (en[3]) begin
      rem4 <= rem_full[13:0];
      tile4 <= tile_full[18:0];
    end
    if (en[4]) begin
      prod5 <= 48'({rem4, 7'b0}) * 48'(tmps_pkg::frac_recip_of(detail));
      tile5 <= tile4;
    end
    if (en[5]) begin
      texel <= prod5[35+tmps_pkg::PIX_W-1:35];
      tile <= tile5;
    end
  end

endmodule

FILE: sv/tmps_lookup.sv
module tmps_lookup (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       st_valid,
  input  tmps_pkg::item_t            st_item,
  input  logic signed [18:0]         tile_x,
  input  logic signed [18:0]         tile_z,
  input  logic [tmps_pkg::PIX_W-1:0] pix_x,
  input  logic [tmps_pkg::PIX_W-1:0] pix_z,
  input  logic [1:0]                 world,
  input  logic [1:0]                 detail,
  output logic                       out_valid,
  output logic                       out_hit,
  output logic [15:0]                out_color,
  output logic [8:0]                 out_x,
  output logic [8:0]                 out_y
);

  logic [tmps_pkg::TILE_SLOTS-1:0] tag_ok;
  logic [1:0] tag_wld [tmps_pkg::TILE_SLOTS];
  logic [1:0] tag_det [tmps_pkg::TILE_SLOTS];
  logic signed [16:0] tag_tx [tmps_pkg::TILE_SLOTS];
  logic signed [16:0] tag_tz [tmps_pkg::TILE_SLOTS];
  logic [15:0] texels [tmps_pkg::TEXEL_DEPTH];
  logic [15:0] rdata;

  logic [tmps_pkg::TILE_SLOTS-1:0] match;
  logic [tmps_pkg::TILE_SLOTS-1:0] first;
  logic any_hit;
  logic [3:0] hit_slot;
  logic is_render;
  logic tag_wr;
  logic tex_wr;
  logic [tmps_pkg::TEXEL_AW-1:0] raddr;
  logic [tmps_pkg::TEXEL_AW-1:0] waddr;

  assign is_render = st_valid && (st_item.opcode == tmps_pkg::OP_RENDER);
  assign tag_wr = en && st_valid && (st_item.opcode == tmps_pkg::OP_TAG)
                  && (st_item.slot < 4'(tmps_pkg::TILE_SLOTS));
  assign tex_wr = en && st_valid && (st_item.opcode == tmps_pkg::OP_TEXEL)
                  && (st_item.slot < 4'(tmps_pkg::TILE_SLOTS));

  // lowest matching slot wins
  always_comb begin
    any_hit = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < tmps_pkg::TILE_SLOTS; i++) begin
      match[i] = st_valid && tag_ok[i] && (tag_wld[i] == world) && (tag_det[i] == detail)
                 && (19'(tag_tx[i]) == tile_x) && (19'(tag_tz[i]) == tile_z);
      first[i] = match[i] && !any_hit;
      if (first[i]) begin
        hit_slot = 4'(i);
      end
      any_hit = any_hit || match[i];
    end
  end

  assign raddr = tmps_pkg::TEXEL_AW'({hit_slot, pix_z, pix_x});
  assign waddr = tmps_pkg::TEXEL_AW'({st_item.slot, st_item.texel_index});

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_ok <= '0;
      out_valid <= 1'b0;
    end else begin
      if (tag_wr) begin
        tag_ok[st_item.slot] <= st_item.tag_valid;
      end
      if (en) begin
        out_valid <= is_render;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tag_wr) begin
      tag_wld[st_item.slot] <= st_item.tag_world;
      tag_det[st_item.slot] <= st_item.tag_detail;
      tag_tx[st_item.slot] <= st_item.tag_tile_x;
      tag_tz[st_item.slot] <= st_item.tag_tile_z;
    end
    if (en) begin
      out_hit <= any_hit;
      out_x <= st_item.screen_x;
      out_y <= st_item.screen_y;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (tex_wr) begin
        texels[waddr] <= st_item.texel_value;
      end
      rdata <= texels[raddr];
    end
  end

  assign out_color = out_hit ? rdata : tmps_pkg::FILL_COLOR;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");
  a_one_slot: assert property (@(posedge clk) disable iff (rst) $onehot0(first))
    else $error("more than one slot selected");
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    en && st_valid && (st_item.opcode != tmps_pkg::OP_RENDER) |=> !out_valid)
    else $error("write transaction produced a result");

endmodule
